/* rtl/playback_queue_completion_tracker_unit_assert.svh */
// Assertion macros for the playback queue completion tracker.
// Both expect clk_i and rst_ni in the scope of the use.
`ifndef PLAYBACK_QUEUE_COMPLETION_TRACKER_UNIT_ASSERT_SVH
`define PLAYBACK_QUEUE_COMPLETION_TRACKER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PQCT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PQCT_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define PQCT_ASSERT(name, prop, msg)
`define PQCT_ASSERT_IMPL(name, ante, cons, msg)
`endif
`endif

/* rtl/pqct_pkg.sv */
package pqct_pkg;

  // Default sizing
  localparam int DEF_PENDING_SLOTS = 8;
  localparam int DEF_QUEUE_BYTES   = 65536;

  // Bits retired per cycle by the serial dividers
  localparam int DIV_STEP = 4;

  // Stream widths
  localparam int IN_W       = 72;
  localparam int USER_W     = 3;
  localparam int OUT_W      = 176;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Field widths
  localparam int CNT_W   = 17;
  localparam int EPOCH_W = 32;
  localparam int FRAG_W  = 15;
  localparam int FRAME_W = 3;
  localparam int LAT_W   = 4;
  localparam int DELAY_W = 31;
  localparam int FR_W    = 9;
  localparam int PTR_W   = 16;

  localparam logic [DELAY_W-1:0] DELAY_CAP = 31'h7FFF_FFFF;
  localparam int FRAG_SAT = 511;

  // Register reset values
  localparam logic [16:0] RST_BUFFER_LIMIT   = 17'd65536;
  localparam logic [14:0] RST_FRAGMENT_SIZE  = 15'd4096;
  localparam logic [2:0]  RST_FRAME_SIZE     = 3'd1;
  localparam logic        RST_OUTPUT_ENABLED = 1'b1;
  localparam logic [3:0]  RST_LATENCY_BLOCKS = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_LIMIT   = 3'd0,
    CFG_FRAGMENT_SIZE  = 3'd1,
    CFG_FRAME_SIZE     = 3'd2,
    CFG_OUTPUT_ENABLED = 3'd3,
    CFG_LATENCY_BLOCKS = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_ENQUEUE = 3'd0,
    OP_FILL    = 3'd1,
    OP_QUERY   = 3'd2,
    OP_RESET   = 3'd3,
    OP_PAD     = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RET,
    S_OP,
    S_BOOK,
    S_MERGE,
    S_STAT,
    S_SUM,
    S_DONE
  } state_e;

  // One pending completion slot
  typedef struct packed {
    logic [31:0] epoch;
    logic [31:0] bytes;
    logic [31:0] blocks;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

/* rtl/pqct_ram.sv */
module pqct_ram #(
  parameter int WIDTH = pqct_pkg::SLOT_W,
  parameter int DEPTH = pqct_pkg::DEF_PENDING_SLOTS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pqct_div.sv */
module pqct_div #(
  parameter int NW   = 17,
  parameter int DW   = 3,
  parameter int STEP = pqct_pkg::DIV_STEP
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int ITER = (NW + STEP - 1) / STEP;
  localparam int NP   = ITER * STEP;
  localparam int CW   = $clog2(ITER + 1);

  logic [NP-1:0] sh_q, sh_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] div_q, div_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Restoring division, STEP quotient bits per cycle
  always_comb begin
    logic [DW:0]   r;
    logic [NP-1:0] s;
    r = rem_q;
    s = sh_q;
    for (int k = 0; k < STEP; k++) begin
      r = {r[DW-1:0], s[NP-1]};
      s = {s[NP-2:0], 1'b0};
      if (r >= {1'b0, div_q}) begin
        r    = r - {1'b0, div_q};
        s[0] = 1'b1;
      end
    end
    sh_d  = sh_q;
    rem_d = rem_q;
    div_d = div_q;
    cnt_d = cnt_q;
    if (start_i) begin
      sh_d  = NP'(dividend_i);
      rem_d = '0;
      div_d = divisor_i;
      cnt_d = CW'(ITER);
    end else if (cnt_q != '0) begin
      sh_d  = s;
      rem_d = r;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = sh_q[NW-1:0];
  assign rem_o  = rem_q[DW-1:0];

endmodule

/* rtl/playback_queue_completion_tracker_unit.sv */
// Playback queue completion tracker: byte accounting for a playback queue.
// Input channel s_axis_*: one operation per item (enqueue, fill, query, reset,
// pad); the opcode rides on tuser, the operands on tdata. Output channel
// m_axis_*: exactly one status item per input item, in order.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i, write only while idle.
// Steps: the retirement walk (one slot a cycle) runs beside the frame divider,
// then the operation, booking of a completion, and the delay sum walk over the
// pending slots (one slot a cycle) beside the free fragment and 64-bit play
// pointer dividers; the status item then loads into the output register.
// Throughput is one item at a time; the next item is taken while the last
// status item still waits in the output register.
// Reset clears the queue, ring pointers, totals and restores register
// defaults; the slot RAM is not cleared (slots are read only once written).
// When the receiver stalls, the status item is held and the block completes
// at most one further item, then waits with tready low.
`include "playback_queue_completion_tracker_unit_assert.svh"

module playback_queue_completion_tracker_unit #(
  parameter int PENDING_SLOTS = pqct_pkg::DEF_PENDING_SLOTS,
  parameter int QUEUE_BYTES   = pqct_pkg::DEF_QUEUE_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [pqct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pqct_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Operation items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: byte_count[16:0], frames_consumed[33:17], samples_mixed[34],
  //        fill_count[66:35], zero fill [71:67]
  input  logic [pqct_pkg::IN_W-1:0]       s_axis_tdata,
  // tuser: op[2:0]
  input  logic [pqct_pkg::USER_W-1:0]     s_axis_tuser,
  // Status items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: accepted_bytes[16:0], drained_bytes[33:17], room_bytes[50:34],
  //        free_fragments[59:51], delay_bytes[90:60], played_bytes_low[122:91],
  //        played_blocks[154:123], play_pointer[170:155], room_ready[171],
  //        queue_empty[172], zero fill [175:173]
  output logic [pqct_pkg::OUT_W-1:0]      m_axis_tdata
);

  localparam int SW = $clog2(PENDING_SLOTS);
  localparam int CW = $clog2(PENDING_SLOTS + 1);
  localparam int TW = CW + 1;
  localparam int QW = $clog2(QUEUE_BYTES + 1);
  localparam int LW = (QW > 17) ? QW : 17;

  // Configuration registers
  logic [16:0] buffer_limit_q;
  logic [14:0] fragment_size_q;
  logic [2:0]  frame_size_q;
  logic        output_enabled_q;
  logic [3:0]  latency_blocks_q;

  // Control state
  pqct_pkg::state_e state_q, state_d;
  logic [QW-1:0] queued_q, queued_d;
  logic [SW-1:0] ring_head_q, ring_head_d;
  logic [CW-1:0] ring_count_q, ring_count_d;
  logic [63:0]   pbytes_q, pbytes_d;
  logic [31:0]   pblocks_q, pblocks_d;
  logic          m_valid_q, m_valid_d;

  // Item payload and working registers
  logic [2:0]    op_q, op_d;
  logic [16:0]   count_q, count_d;
  logic [16:0]   frames_q, frames_d;
  logic          mixed_q, mixed_d;
  logic [31:0]   now_q, now_d;
  logic [QW-1:0] accepted_q, accepted_d;
  logic [QW-1:0] consumed_q, consumed_d;
  logic          query_q, query_d;
  logic [31:0]   blocks_out_q, blocks_out_d;
  logic [SW-1:0] rp_q, rp_d;
  logic [CW-1:0] walk_q, walk_d;
  logic [pqct_pkg::DELAY_W-1:0] acc_q, acc_d;
  logic [pqct_pkg::OUT_W-1:0]   m_data_q, m_data_d;

  // Slot RAM
  logic                      ram_we, ram_re;
  logic [SW-1:0]             ram_waddr, ram_raddr;
  pqct_pkg::slot_t           ram_wslot, rd_slot;
  logic [pqct_pkg::SLOT_W-1:0] ram_rdata;

  // Dividers
  logic          s_accept;
  logic          fdiv_busy, frag_busy, ptr_busy, stat_start;
  logic [QW-1:0] fdiv_quo, frag_quo, ptr_rem;
  logic [2:0]    fdiv_rem;

  // Shared combinational values
  logic [LW-1:0] lim_ext;
  logic [QW-1:0] lim_w, fs_w;
  logic [SW-1:0] tail_slot, last_slot;
  logic [TW-1:0] tail_sum;
  logic          retire_op;
  logic [31:0]   due_w;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    if (s == SW'(PENDING_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  assign s_axis_tready = (state_q == pqct_pkg::S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign stat_start    = (state_q == pqct_pkg::S_STAT);
  assign rd_slot       = pqct_pkg::slot_t'(ram_rdata);

  // Effective limit and free space
  assign lim_ext = (LW'(buffer_limit_q) < LW'(QUEUE_BYTES)) ? LW'(buffer_limit_q)
                                                           : LW'(QUEUE_BYTES);
  assign lim_w   = QW'(lim_ext);
  assign fs_w    = (queued_q < lim_w) ? (lim_w - queued_q) : '0;

  // Ring positions
  assign tail_sum  = TW'(ring_head_q) + TW'(ring_count_q);
  assign tail_slot = (tail_sum >= TW'(PENDING_SLOTS)) ? SW'(tail_sum - TW'(PENDING_SLOTS))
                                                      : SW'(tail_sum);
  assign last_slot = (ring_head_q == '0) ? SW'(PENDING_SLOTS - 1) : (ring_head_q - 1'b1);
  assign due_w     = now_q + 32'd1 + 32'(latency_blocks_q);
  assign retire_op = (op_q == pqct_pkg::OP_FILL) || (op_q == pqct_pkg::OP_QUERY) ||
                     (op_q == pqct_pkg::OP_PAD);

  always_comb begin
    logic [QW-1:0] take;
    logic [QW-1:0] cons;
    logic [QW+2:0] prod;
    logic [QW:0]   pad_sum;
    logic [2:0]    pad_amt;
    logic [32:0]   sum33;
    logic [8:0]    fr;
    logic [15:0]   ptr;
    logic          wr_ready;
    logic          empty;
    logic [31:0]   blocks;

    take     = '0;
    cons     = '0;
    prod     = '0;
    pad_amt  = frame_size_q - fdiv_rem;
    pad_sum  = {1'b0, queued_q} + (QW+1)'(pad_amt);
    sum33    = 33'(acc_q) + 33'(rd_slot.bytes);
    fr       = (fragment_size_q == '0) ? 9'd0 :
               (frag_quo > QW'(pqct_pkg::FRAG_SAT)) ? 9'(pqct_pkg::FRAG_SAT) : frag_quo[8:0];
    ptr      = (lim_w == '0) ? 16'd0 : 16'(ptr_rem);
    wr_ready = (LW'(fs_w) >= LW'(fragment_size_q));
    empty    = (queued_q == '0) && (ring_count_q == '0);
    blocks   = query_q ? blocks_out_q : pblocks_q;

    state_d      = state_q;
    queued_d     = queued_q;
    ring_head_d  = ring_head_q;
    ring_count_d = ring_count_q;
    pbytes_d     = pbytes_q;
    pblocks_d    = pblocks_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    op_d         = op_q;
    count_d      = count_q;
    frames_d     = frames_q;
    mixed_d      = mixed_q;
    now_d        = now_q;
    accepted_d   = accepted_q;
    consumed_d   = consumed_q;
    query_d      = query_q;
    blocks_out_d = blocks_out_q;
    rp_d         = rp_q;
    walk_d       = walk_q;
    acc_d        = acc_q;
    ram_we       = 1'b0;
    ram_waddr    = tail_slot;
    ram_wslot    = '{epoch: due_w, bytes: 32'(consumed_q), blocks: 32'd1};
    ram_re       = 1'b0;
    ram_raddr    = ring_head_q;

    // Drop the held status item once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      pqct_pkg::S_IDLE: begin
        if (s_accept) begin
          op_d       = s_axis_tuser;
          count_d    = s_axis_tdata[16:0];
          frames_d   = s_axis_tdata[33:17];
          mixed_d    = s_axis_tdata[34];
          now_d      = s_axis_tdata[66:35];
          accepted_d = '0;
          consumed_d = '0;
          query_d    = 1'b0;
          // Fetch the head slot for retirement
          ram_re     = 1'b1;
          ram_raddr  = ring_head_q;
          state_d    = pqct_pkg::S_RET;
        end
      end

      pqct_pkg::S_RET: begin
        // Retire the head slot while it is due, one slot a cycle
        if (retire_op && (ring_count_q != '0) && !(rd_slot.epoch > now_q)) begin
          pbytes_d     = pbytes_q + 64'(rd_slot.bytes);
          pblocks_d    = pblocks_q + rd_slot.blocks;
          ring_head_d  = slot_inc(ring_head_q);
          ring_count_d = ring_count_q - 1'b1;
          if (ring_count_q != CW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = slot_inc(ring_head_q);
          end else begin
            state_d = pqct_pkg::S_OP;
          end
        end else begin
          state_d = pqct_pkg::S_OP;
        end
      end

      pqct_pkg::S_OP: begin
        if (!fdiv_busy) begin
          state_d = pqct_pkg::S_STAT;
          case (op_q)
            pqct_pkg::OP_ENQUEUE: begin
              take       = (LW'(count_q) < LW'(fs_w)) ? QW'(count_q) : fs_w;
              accepted_d = take;
              queued_d   = queued_q + take;
            end
            pqct_pkg::OP_FILL: begin
              if (output_enabled_q && (frame_size_q != '0) && (fdiv_quo != '0)) begin
                take       = (LW'(frames_q) < LW'(fdiv_quo)) ? QW'(frames_q) : fdiv_quo;
                prod       = (QW+3)'(take) * (QW+3)'(frame_size_q);
                cons       = QW'(prod);
                consumed_d = cons;
                queued_d   = queued_q - cons;
                if (mixed_q && (cons != '0)) begin
                  state_d = pqct_pkg::S_BOOK;
                end
              end
            end
            pqct_pkg::OP_QUERY: begin
              query_d      = 1'b1;
              blocks_out_d = pblocks_q;
              pblocks_d    = '0;
            end
            pqct_pkg::OP_RESET: begin
              queued_d     = '0;
              ring_head_d  = '0;
              ring_count_d = '0;
              pbytes_d     = '0;
              pblocks_d    = '0;
            end
            pqct_pkg::OP_PAD: begin
              if ((frame_size_q != '0) && (fdiv_rem != '0) &&
                  (pad_sum <= (QW+1)'(QUEUE_BYTES))) begin
                queued_d = QW'(pad_sum);
              end
            end
            default: begin
            end
          endcase
        end
      end

      pqct_pkg::S_BOOK: begin
        if (ring_count_q >= CW'(PENDING_SLOTS)) begin
          // Full ring: read the newest slot and merge into it
          ram_re    = 1'b1;
          ram_raddr = last_slot;
          state_d   = pqct_pkg::S_MERGE;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = tail_slot;
          ring_count_d = ring_count_q + 1'b1;
          state_d      = pqct_pkg::S_STAT;
        end
      end

      pqct_pkg::S_MERGE: begin
        ram_we    = 1'b1;
        ram_waddr = last_slot;
        ram_wslot = '{epoch:  due_w,
                      bytes:  rd_slot.bytes + 32'(consumed_q),
                      blocks: rd_slot.blocks + 32'd1};
        state_d   = pqct_pkg::S_STAT;
      end

      pqct_pkg::S_STAT: begin
        // The fragment and play pointer dividers start here; begin the pending byte walk
        acc_d     = pqct_pkg::DELAY_W'(queued_q);
        walk_d    = '0;
        ram_re    = (ring_count_q != '0);
        ram_raddr = ring_head_q;
        rp_d      = slot_inc(ring_head_q);
        state_d   = pqct_pkg::S_SUM;
      end

      pqct_pkg::S_SUM: begin
        if (walk_q != ring_count_q) begin
          acc_d  = (sum33 > 33'(pqct_pkg::DELAY_CAP)) ? pqct_pkg::DELAY_CAP
                                                      : sum33[pqct_pkg::DELAY_W-1:0];
          walk_d = walk_q + 1'b1;
          if (CW'(walk_q + 1'b1) != ring_count_q) begin
            ram_re    = 1'b1;
            ram_raddr = rp_q;
            rp_d      = slot_inc(rp_q);
          end
        end else if (!frag_busy && !ptr_busy) begin
          state_d = pqct_pkg::S_DONE;
        end
      end

      pqct_pkg::S_DONE: begin
        // Load the status item once the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {3'b000, empty, wr_ready, ptr, blocks, pbytes_q[31:0], acc_q, fr,
                       17'(fs_w), 17'(consumed_q), 17'(accepted_q)};
          state_d   = pqct_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pqct_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pqct_pkg::S_IDLE;
      queued_q     <= '0;
      ring_head_q  <= '0;
      ring_count_q <= '0;
      pbytes_q     <= '0;
      pblocks_q    <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      queued_q     <= queued_d;
      ring_head_q  <= ring_head_d;
      ring_count_q <= ring_count_d;
      pbytes_q     <= pbytes_d;
      pblocks_q    <= pblocks_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    count_q      <= count_d;
    frames_q     <= frames_d;
    mixed_q      <= mixed_d;
    now_q        <= now_d;
    accepted_q   <= accepted_d;
    consumed_q   <= consumed_d;
    query_q      <= query_d;
    blocks_out_q <= blocks_out_d;
    rp_q         <= rp_d;
    walk_q       <= walk_d;
    acc_q        <= acc_d;
    m_data_q     <= m_data_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_limit_q   <= pqct_pkg::RST_BUFFER_LIMIT;
      fragment_size_q  <= pqct_pkg::RST_FRAGMENT_SIZE;
      frame_size_q     <= pqct_pkg::RST_FRAME_SIZE;
      output_enabled_q <= pqct_pkg::RST_OUTPUT_ENABLED;
      latency_blocks_q <= pqct_pkg::RST_LATENCY_BLOCKS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pqct_pkg::CFG_BUFFER_LIMIT:   buffer_limit_q   <= cfg_data_i[16:0];
        pqct_pkg::CFG_FRAGMENT_SIZE:  fragment_size_q  <= cfg_data_i[14:0];
        pqct_pkg::CFG_FRAME_SIZE:     frame_size_q     <= cfg_data_i[2:0];
        pqct_pkg::CFG_OUTPUT_ENABLED: output_enabled_q <= cfg_data_i[0];
        pqct_pkg::CFG_LATENCY_BLOCKS: latency_blocks_q <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  pqct_ram #(
    .WIDTH (pqct_pkg::SLOT_W),
    .DEPTH (PENDING_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wslot),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Queued bytes split into whole frames and a remainder
  pqct_div #(
    .NW (QW),
    .DW (3)
  ) u_frame_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_accept),
    .dividend_i (queued_q),
    .divisor_i  (frame_size_q),
    .busy_o     (fdiv_busy),
    .quo_o      (fdiv_quo),
    .rem_o      (fdiv_rem)
  );

  // Free fragments
  pqct_div #(
    .NW (QW),
    .DW (15)
  ) u_frag_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (stat_start),
    .dividend_i (fs_w),
    .divisor_i  (fragment_size_q),
    .busy_o     (frag_busy),
    .quo_o      (frag_quo),
    .rem_o      ()
  );

  // Play pointer: played bytes modulo the effective limit
  pqct_div #(
    .NW (64),
    .DW (QW)
  ) u_ptr_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (stat_start),
    .dividend_i (pbytes_q),
    .divisor_i  (lim_w),
    .busy_o     (ptr_busy),
    .quo_o      (),
    .rem_o      (ptr_rem)
  );

  // Ring occupancy moves by one slot at a time, or drops to zero on a reset op
  `PQCT_ASSERT_IMPL(a_ring_count_step, ring_count_q != $past(ring_count_q),
    ring_count_q == $past(ring_count_q) + 1 || ring_count_q + 1 == $past(ring_count_q) ||
    ring_count_q == 0, "ring count jumped")
  // No status item is built while a divider is still working
  `PQCT_ASSERT_IMPL(a_div_done, state_q == pqct_pkg::S_DONE,
    !fdiv_busy && !frag_busy && !ptr_busy, "status built before dividers finished")
  // Occupancy, head and queued bytes stay in range
  `PQCT_ASSERT(a_state_range,
    ring_count_q <= PENDING_SLOTS && ring_head_q < PENDING_SLOTS &&
    queued_q <= QUEUE_BYTES, "queue state out of range")

endmodule
